// File: rtl/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the biquad filter checker.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while the active-low reset is asserted.
`define BQD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define BQD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bqd_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Biquad filter package
// Fixed-point formats, beat types and register indexes of the biquad filter.
//------------------------------------------------------------------------------
package bqd_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int SAMPLE_FRAC  = SAMPLE_BITS - 1;
  localparam int OUT_BITS     = 24;
  localparam int OUT_FRAC     = 15;
  localparam int COEF_FRAC    = 16;
  localparam int MAX_FRAC     = (SAMPLE_FRAC > OUT_FRAC) ? SAMPLE_FRAC : OUT_FRAC;
  localparam int X_SHIFT      = MAX_FRAC - SAMPLE_FRAC;
  localparam int Y_SHIFT      = MAX_FRAC - OUT_FRAC;
  localparam int ROUND_SHIFT  = COEF_FRAC + MAX_FRAC - OUT_FRAC;
  localparam int NUM_COEFS    = 5;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    IDX_B0 = 3'd0,
    IDX_B1 = 3'd1,
    IDX_B2 = 3'd2,
    IDX_A1 = 3'd3,
    IDX_A2 = 3'd4
  } coef_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          buffer_end;
  } bqd_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] sample_out;
    logic                       overflow;
    logic                       buffer_end_out;
  } bqd_out_t;

endpackage

// File: rtl/bqd_coef_regs.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Biquad coefficient registers
// Holds the five filter coefficients, written through the configuration port.
//------------------------------------------------------------------------------
module bqd_coef_regs import bqd_pkg::*; #(
  parameter int COEF_BITS = 20,
  parameter int COEF_W    = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]              cfg_index_i,
  input  logic [COEF_BITS-1:0]                 cfg_data_i,
  output logic [NUM_COEFS-1:0][COEF_W-1:0]     coef_o
);

  // The b0 entry sits in the lowest bits and resets to 1.0; all others reset to zero.
  localparam logic [NUM_COEFS*COEF_W-1:0] COEF_RESET = (NUM_COEFS*COEF_W)'(1) << COEF_FRAC;

  logic [NUM_COEFS-1:0][COEF_W-1:0] coef_q;
  logic [NUM_COEFS-1:0][COEF_W-1:0] coef_d;
  logic [COEF_W-1:0]                wr_value;

  assign wr_value = COEF_W'($signed(cfg_data_i));

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (coef_idx_e'(cfg_index_i))
        IDX_B0: coef_d[IDX_B0] = wr_value;
        IDX_B1: coef_d[IDX_B1] = wr_value;
        IDX_B2: coef_d[IDX_B2] = wr_value;
        IDX_A1: coef_d[IDX_A1] = wr_value;
        IDX_A2: coef_d[IDX_A2] = wr_value;
        default: coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// File: rtl/bqd_datapath.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Biquad datapath
// Five products summed exactly, rounded half up and saturated to the output.
//------------------------------------------------------------------------------
module bqd_datapath import bqd_pkg::*; #(
  parameter int COEF_W = 20
) (
  input  logic signed [SAMPLE_BITS-1:0]      x_i,
  input  logic                               buffer_end_i,
  input  logic signed [SAMPLE_BITS-1:0]      x1_i,
  input  logic signed [SAMPLE_BITS-1:0]      x2_i,
  input  logic signed [OUT_BITS-1:0]         y1_i,
  input  logic signed [OUT_BITS-1:0]         y2_i,
  input  logic [NUM_COEFS-1:0][COEF_W-1:0]   coef_i,
  output bqd_out_t                           result_o
);

  localparam int ACC_W = COEF_W + MAX_FRAC + 11;
  localparam int R_W   = ACC_W - ROUND_SHIFT;
  localparam logic signed [R_W-1:0] Y_MAX = R_W'((2 ** (OUT_BITS - 1)) - 1);
  localparam logic signed [R_W-1:0] Y_MIN = R_W'(-(2 ** (OUT_BITS - 1)));

  logic signed [SAMPLE_BITS+COEF_W-1:0] p_b0;
  logic signed [SAMPLE_BITS+COEF_W-1:0] p_b1;
  logic signed [SAMPLE_BITS+COEF_W-1:0] p_b2;
  logic signed [OUT_BITS+COEF_W-1:0]    p_a1;
  logic signed [OUT_BITS+COEF_W-1:0]    p_a2;
  logic signed [ACC_W-1:0]              acc;
  logic signed [ACC_W-1:0]              acc_rnd;
  logic signed [R_W-1:0]                r;

  assign p_b0 = x_i  * $signed(coef_i[IDX_B0]);
  assign p_b1 = x1_i * $signed(coef_i[IDX_B1]);
  assign p_b2 = x2_i * $signed(coef_i[IDX_B2]);
  assign p_a1 = y1_i * $signed(coef_i[IDX_A1]);
  assign p_a2 = y2_i * $signed(coef_i[IDX_A2]);

  assign acc = (ACC_W'(p_b0) <<< X_SHIFT) + (ACC_W'(p_b1) <<< X_SHIFT)
             + (ACC_W'(p_b2) <<< X_SHIFT) - (ACC_W'(p_a1) <<< Y_SHIFT)
             - (ACC_W'(p_a2) <<< Y_SHIFT);

  assign acc_rnd = acc + (ACC_W'(1) <<< (ROUND_SHIFT - 1));
  assign r       = acc_rnd[ACC_W-1:ROUND_SHIFT];

  always_comb begin
    result_o.buffer_end_out = buffer_end_i;
    priority if (r > Y_MAX) begin
      result_o.sample_out = Y_MAX[OUT_BITS-1:0];
      result_o.overflow   = 1'b1;
    end else if (r < Y_MIN) begin
      result_o.sample_out = Y_MIN[OUT_BITS-1:0];
      result_o.overflow   = 1'b1;
    end else begin
      result_o.sample_out = r[OUT_BITS-1:0];
      result_o.overflow   = 1'b0;
    end
  end

endmodule

// File: rtl/biquad_iir_filter.sv
`timescale 1ns / 1ps
// A beat accepted into the input register moves to the result register once the
// output is ready, and leaves the output once the output is not stalled.
// Throughput: one sample per cycle while the output is not stalled; the input register,
// the combinational multiply-accumulate path and the result register set that figure.
// Reset empties both stages, clears the sample history and loads b0 with 1.0
// and the other coefficients with zero.
//------------------------------------------------------------------------------
// Biquad IIR filter
// Direct form 1 biquad with registered input and result stages.
//------------------------------------------------------------------------------
module biquad_iir_filter import bqd_pkg::*; #(
  parameter int COEF_BITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  bqd_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output bqd_out_t                out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COEF_BITS-1:0]    cfg_data_i
);

  localparam int COEF_W = (COEF_BITS > COEF_FRAC + 1) ? COEF_BITS : COEF_FRAC + 2;

  logic [NUM_COEFS-1:0][COEF_W-1:0] coef;
  logic                             in_valid_q;
  bqd_in_t                          in_data_q;
  logic                             out_valid_q;
  bqd_out_t                         out_data_q;
  bqd_out_t                         result;
  logic                             out_ready;
  logic                             fire;
  logic signed [SAMPLE_BITS-1:0]    x1_q, x1_d, x2_q, x2_d;
  logic signed [OUT_BITS-1:0]       y1_q, y1_d, y2_q, y2_d;

  bqd_coef_regs #(
    .COEF_BITS(COEF_BITS),
    .COEF_W   (COEF_W)
  ) u_coef_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  bqd_datapath #(
    .COEF_W(COEF_W)
  ) u_datapath (
    .x_i         (in_data_q.sample_in),
    .buffer_end_i(in_data_q.buffer_end),
    .x1_i        (x1_q),
    .x2_i        (x2_q),
    .y1_i        (y1_q),
    .y2_i        (y2_q),
    .coef_i      (coef),
    .result_o    (result)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_comb begin
    x1_d = x1_q;
    x2_d = x2_q;
    y1_d = y1_q;
    y2_d = y2_q;
    if (fire) begin
      if (in_data_q.buffer_end) begin
        x1_d = '0;
        x2_d = '0;
        y1_d = '0;
        y2_d = '0;
      end else begin
        x1_d = in_data_q.sample_in;
        x2_d = x1_q;
        y1_d = result.sample_out;
        y2_d = y1_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      x1_q <= x1_d;
      x2_q <= x2_d;
      y1_q <= y1_d;
      y2_q <= y2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/bqd_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Biquad filter checker
// Port-level assertions on the biquad filter, attached by a bind statement.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module bqd_checker import bqd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input bqd_out_t out_data_o
);

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = OUT_BITS'((2 ** (OUT_BITS - 1)) - 1);
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = OUT_BITS'(-(2 ** (OUT_BITS - 1)));

  logic out_hold;
  logic in_take;
  logic ovf_beat;
  logic out_rail;

  assign out_hold = out_valid_o && out_stall_i;
  assign in_take  = in_valid_i && !in_stall_o;
  assign ovf_beat = out_valid_o && out_data_o.overflow;
  assign out_rail = (out_data_o.sample_out == OUT_MAX) || (out_data_o.sample_out == OUT_MIN);

  `BQD_ASSERT(a_out_valid_held, clk_i, rst_ni, out_hold |=> out_valid_o, "stalled beat dropped")
  `BQD_ASSERT(a_out_data_held, clk_i, rst_ni, out_hold |=> $stable(out_data_o), "beat changed")
  `BQD_ASSERT(a_in_stall_cause, clk_i, rst_ni, in_stall_o |-> out_hold, "stall without cause")
  `BQD_ASSERT(a_latency, clk_i, rst_ni, in_take |-> ##2 out_valid_o, "accepted beat lost")
  `BQD_ASSERT(a_ovf_rail, clk_i, rst_ni, ovf_beat |-> out_rail, "overflow off the rails")

endmodule

bind biquad_iir_filter bqd_checker u_bqd_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Biquad filter testbench
// Streams audio samples through the biquad under a series of coefficient
// settings, predicts every filtered sample in fixed point and compares each
// output beat field by field, with random input gaps and output back-pressure.
//------------------------------------------------------------------------------
module tb_top;
  import bqd_pkg::*;

  localparam int COEF_BITS = 20;
  localparam int COEF_ONE = 1 << COEF_FRAC;
  localparam int COEF_HALF = 1 << (COEF_FRAC - 1);
  localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS - 1){1'b1}}};
  localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS - 1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam longint OUT_MAX = (longint'(1) <<< (OUT_BITS - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SAMPLES = 103;
  localparam int CYCLE_LIMIT = 200000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  bqd_in_t                 in_data_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  bqd_out_t                out_data_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [COEF_BITS-1:0]    cfg_data_i = '0;

  logic signed [COEF_BITS-1:0]   coefs [NUM_COEFS] = '{COEF_BITS'(COEF_ONE), '0, '0, '0, '0};
  logic signed [SAMPLE_BITS-1:0] hist_x1 = '0;
  logic signed [SAMPLE_BITS-1:0] hist_x2 = '0;
  logic signed [OUT_BITS-1:0]    hist_y1 = '0;
  logic signed [OUT_BITS-1:0]    hist_y2 = '0;

  bqd_in_t  sample_queue[$];
  bqd_out_t expected_outputs[$];

  bit jitter_on = 1'b1;
  int in_gap = 0;
  int stall_left = 0;
  int sent_beats = 0;
  int taken_beats = 0;
  int out_beats = 0;
  int saturations = 0;
  int buffer_ends = 0;
  int settings = 0;
  int failures = 0;
  int cycles = 0;

  always #10 clk_i = ~clk_i;

  biquad_iir_filter #(
    .COEF_BITS(COEF_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  function automatic bqd_out_t biquad_response(input bqd_in_t beat);
    logic signed [SAMPLE_BITS-1:0] x;
    longint acc;
    longint y;
    bqd_out_t res;
    x = beat.sample_in;
    acc = ((longint'(coefs[IDX_B0]) * longint'(x)) <<< X_SHIFT)
        + ((longint'(coefs[IDX_B1]) * longint'(hist_x1)) <<< X_SHIFT)
        + ((longint'(coefs[IDX_B2]) * longint'(hist_x2)) <<< X_SHIFT)
        - ((longint'(coefs[IDX_A1]) * longint'(hist_y1)) <<< Y_SHIFT)
        - ((longint'(coefs[IDX_A2]) * longint'(hist_y2)) <<< Y_SHIFT);
    acc = acc + (longint'(1) <<< (ROUND_SHIFT - 1));
    y = acc >>> ROUND_SHIFT;
    res.overflow = 1'b0;
    if (y > OUT_MAX) begin
      y = OUT_MAX;
      res.overflow = 1'b1;
    end else if (y < OUT_MIN) begin
      y = OUT_MIN;
      res.overflow = 1'b1;
    end
    res.sample_out = y[OUT_BITS-1:0];
    res.buffer_end_out = beat.buffer_end;
    if (beat.buffer_end) begin
      hist_x1 = '0;
      hist_x2 = '0;
      hist_y1 = '0;
      hist_y2 = '0;
    end else begin
      hist_x2 = hist_x1;
      hist_x1 = x;
      hist_y2 = hist_y1;
      hist_y1 = y[OUT_BITS-1:0];
    end
    return res;
  endfunction

  // Input side: one beat per handshake, optionally followed by a short gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sent_beats != taken_beats) begin
      end else if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        in_data_i <= sample_queue.pop_front();
        in_valid_i <= 1'b1;
        sent_beats++;
        if (jitter_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    bqd_out_t exp_beat;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        out_beats++;
        if (expected_outputs.size() == 0) begin
          $error("output beat with no sample pending: %0d", out_data_o.sample_out);
          failures++;
        end else begin
          exp_beat = expected_outputs.pop_front();
          if (exp_beat.overflow) saturations++;
          if (exp_beat.buffer_end_out) buffer_ends++;
          if (out_data_o.sample_out !== exp_beat.sample_out) begin
            $error("sample_out: expected %0d, got %0d", exp_beat.sample_out,
                   out_data_o.sample_out);
            failures++;
          end
          if (out_data_o.overflow !== exp_beat.overflow) begin
            $error("overflow: expected %0b, got %0b", exp_beat.overflow, out_data_o.overflow);
            failures++;
          end
          if (out_data_o.buffer_end_out !== exp_beat.buffer_end_out) begin
            $error("buffer_end_out: expected %0b, got %0b", exp_beat.buffer_end_out,
                   out_data_o.buffer_end_out);
            failures++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_outputs.push_back(biquad_response(in_data_i));
        taken_beats++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send(input logic [SAMPLE_BITS-1:0] value, input logic last);
    sample_queue.push_back('{sample_in: value, buffer_end: last});
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || sent_beats != taken_beats ||
           expected_outputs.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [COEF_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    if (idx < NUM_COEFS) coefs[idx] = value;
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic set_filter(input logic [COEF_BITS-1:0] b0, input logic [COEF_BITS-1:0] b1,
                            input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] a1,
                            input logic [COEF_BITS-1:0] a2);
    write_coef(IDX_B0, b0);
    write_coef(IDX_B1, b1);
    write_coef(IDX_B2, b2);
    write_coef(IDX_A1, a1);
    write_coef(IDX_A2, a2);
    end_writes();
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return SAMPLE_BITS'($urandom_range(0, 511) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] pick_coef(input bit feedback, input bit wild);
    if (wild) begin
      case ($urandom_range(0, 5))
        0: return COEF_MAX;
        1: return COEF_MIN;
        2: return '0;
        3: return COEF_BITS'($urandom);
        default: ;
      endcase
    end
    if (feedback) return COEF_BITS'(int'($urandom_range(0, 3 * COEF_HALF)) - 3 * COEF_HALF / 2);
    return COEF_BITS'(int'($urandom_range(0, COEF_ONE)) - COEF_HALF);
  endfunction

  task automatic queue_buffers(input int count);
    int len;
    while (count > 0) begin
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 48);
      if (len > count) len = count;
      for (int i = 0; i < len; i++) send(pick_sample(), i == len - 1);
      count -= len;
    end
  endtask

  initial begin
    bit wild;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MIN, 1'b0);
    send(SAMPLE_BITS'(-1), 1'b1);
    send(SAMPLE_BITS'(1), 1'b0);
    wait_idle();

    // Writes to indexes past the last coefficient must leave the filter alone.
    for (int k = NUM_COEFS; k < (1 << CFG_IDX_BITS); k++)
      write_coef(CFG_IDX_BITS'(k), COEF_BITS'($urandom));
    end_writes();
    send(SAMPLE_MAX, 1'b1);
    wait_idle();

    // A gain of one half puts odd samples exactly on the rounding midpoint.
    set_filter(COEF_BITS'(COEF_HALF), '0, '0, '0, '0);
    send(SAMPLE_BITS'(1), 1'b0);
    send(SAMPLE_BITS'(-1), 1'b0);
    send(SAMPLE_BITS'(3), 1'b0);
    send(SAMPLE_BITS'(-3), 1'b1);
    wait_idle();

    set_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MIN, 1'b1);
    wait_idle();

    set_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MIN, 1'b0);
    send(SAMPLE_BITS'(100), 1'b1);
    wait_idle();

    // The sample after a buffer end must see an empty history.
    set_filter(COEF_BITS'(COEF_ONE), COEF_BITS'(COEF_HALF), '0, -COEF_BITS'(COEF_HALF), '0);
    send(SAMPLE_BITS'(20000), 1'b0);
    send(SAMPLE_BITS'(20000), 1'b1);
    send(SAMPLE_BITS'(20000), 1'b0);
    send('0, 1'b1);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      jitter_on = (ph % 4 != 3) && (ph != RANDOM_PHASES - 1);
      wild = ph % 2;
      if (ph == 0) set_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      else if (ph == 1) set_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      else set_filter(pick_coef(1'b0, wild), pick_coef(1'b0, wild), pick_coef(1'b0, wild),
                      pick_coef(1'b1, wild), pick_coef(1'b1, wild));
      if (ph == 4) begin
        queue_buffers(PHASE_SAMPLES / 2);
        wait_idle();
        queue_buffers(PHASE_SAMPLES - PHASE_SAMPLES / 2);
      end else begin
        queue_buffers(PHASE_SAMPLES);
      end
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    $display("Filtered %0d samples into %0d output beats under %0d coefficient settings.",
             taken_beats, out_beats, settings);
    $display("Saw %0d saturated results and %0d buffer ends; %0d mismatches.",
             saturations, buffer_ends, failures);
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
